// File: src/sorted_closest_value_search_assert.svh
// Assertion macros shared by the sorted closest value search modules.
// No dependencies; included by the controller and the datapath.
`ifndef SORTED_CLOSEST_VALUE_SEARCH_ASSERT_SVH
`define SORTED_CLOSEST_VALUE_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SCVS_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SCVS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/scvs_pkg.sv
// Shared types and constants for the sorted closest value search block.
// No dependencies; used by the controller, the datapath and the top module.
`timescale 1ns / 1ps
`default_nettype none

package scvs_pkg;

  localparam int DATA_W          = 32;
  localparam int IDX_W           = 10;
  localparam int NUM_W           = 11;
  localparam int S_TDATA_W       = 48;
  localparam int DEF_TABLE_DEPTH = 1024;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CMP,
    ST_FIN_A,
    ST_FIN_B,
    ST_PICK,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;   // input transfer this cycle
    logic probe;    // read the probe entry
    logic step;     // narrow the search range from the probe result
    logic fin_a;    // read the lower (or only) candidate
    logic fin_b;    // capture lower, read upper candidate
    logic pick;     // choose the nearer candidate
    logic load;     // move result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic count_zero;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// File: src/scvs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module scvs_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/scvs_ctrl.sv
// Controller state machine for the sorted closest value search.
// Depends on scvs_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_closest_value_search_assert.svh"

module scvs_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  input  wire logic            is_query,
  output logic                 s_tready,
  input  wire scvs_pkg::stat_t st,
  output scvs_pkg::cmd_t       cmd
);

  scvs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scvs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      scvs_pkg::ST_IDLE: begin
        if (s_tvalid && is_query) state_next = scvs_pkg::ST_SEARCH;
      end
      scvs_pkg::ST_SEARCH: begin
        state_next = st.count_zero ? scvs_pkg::ST_FIN_A : scvs_pkg::ST_CMP;
      end
      scvs_pkg::ST_CMP:    state_next = scvs_pkg::ST_SEARCH;
      scvs_pkg::ST_FIN_A:  state_next = scvs_pkg::ST_FIN_B;
      scvs_pkg::ST_FIN_B:  state_next = scvs_pkg::ST_PICK;
      scvs_pkg::ST_PICK:   state_next = scvs_pkg::ST_DONE;
      scvs_pkg::ST_DONE: begin
        if (st.out_free) state_next = scvs_pkg::ST_IDLE;
      end
      default:             state_next = scvs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      scvs_pkg::ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      scvs_pkg::ST_SEARCH: cmd.probe = !st.count_zero;
      scvs_pkg::ST_CMP:    cmd.step  = 1'b1;
      scvs_pkg::ST_FIN_A:  cmd.fin_a = 1'b1;
      scvs_pkg::ST_FIN_B:  cmd.fin_b = 1'b1;
      scvs_pkg::ST_PICK:   cmd.pick  = 1'b1;
      scvs_pkg::ST_DONE:   cmd.load  = st.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

  `SCVS_ASSERT_NEXT(a_probe_then_cmp, clk, rst,
    (state == scvs_pkg::ST_SEARCH) && !st.count_zero, state == scvs_pkg::ST_CMP,
    "probe read not followed by compare")

  `SCVS_ASSERT_NOW(a_cmp_after_probe, clk, rst,
    state == scvs_pkg::ST_CMP, $past(cmd.probe),
    "compare without a probe read one cycle earlier")

endmodule

`default_nettype wire

// File: src/scvs_dp.sv
// Datapath for the sorted closest value search: table RAM, search range,
// candidate selection and output register. Depends on scvs_pkg and scvs_ram.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_closest_value_search_assert.svh"

module scvs_dp #(
  parameter int TABLE_DEPTH = scvs_pkg::DEF_TABLE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [scvs_pkg::NUM_W-1:0]    cfg_wdata,
  input  wire logic                          is_query,
  input  wire logic [scvs_pkg::IDX_W-1:0]    entry_index,
  input  wire logic [scvs_pkg::DATA_W-1:0]   data_value,
  input  wire scvs_pkg::cmd_t                cmd,
  output scvs_pkg::stat_t                    st,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [scvs_pkg::DATA_W-1:0]   m_tdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int DW = scvs_pkg::DATA_W;

  logic [scvs_pkg::NUM_W-1:0] num_elements;
  logic [CW-1:0]              n_cur, n_q, first, count;
  logic [CW-1:0]              half, probe, lo_sel;
  logic signed [DW-1:0]       target;
  logic [DW-1:0]              lo, res, rdata;
  logic [AW-1:0]              raddr;
  logic                       ram_we, single, at_front, past_end;
  logic [DW:0]                d_lo, d_hi, mag_lo, mag_hi;
  logic [CW:0]                span;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_elements <= scvs_pkg::NUM_W'(1);
    end else if (cfg_we) begin
      num_elements <= cfg_wdata;
    end
  end

  // Clamp the count in use to 1..TABLE_DEPTH
  always_comb begin
    if (num_elements == '0) begin
      n_cur = CW'(1);
    end else if (32'(num_elements) > 32'(TABLE_DEPTH)) begin
      n_cur = CW'(TABLE_DEPTH);
    end else begin
      n_cur = CW'(num_elements);
    end
  end

  assign ram_we = cmd.accept && (is_query == scvs_pkg::REQ_WRITE)
                  && (32'(entry_index) < 32'(TABLE_DEPTH));

  assign half     = count >> 1;
  assign probe    = first + half;
  assign at_front = (first == '0);
  assign past_end = (first >= n_q);
  assign lo_sel   = at_front ? '0 : (past_end ? n_q - CW'(1) : first - CW'(1));

  always_comb begin
    if (cmd.probe) begin
      raddr = AW'(probe);
    end else if (cmd.fin_a) begin
      raddr = AW'(lo_sel);
    end else begin
      raddr = AW'(first);
    end
  end

  scvs_ram #(
    .W     (DW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(entry_index)),
    .wdata (data_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      first <= '0;
      count <= '0;
      n_q   <= CW'(1);
    end else if (cmd.accept && (is_query == scvs_pkg::REQ_QUERY)) begin
      first <= '0;
      count <= n_cur;
      n_q   <= n_cur;
    end else if (cmd.step) begin
      // rdata holds the probe entry; move past it when it is below the target
      if ($signed(rdata) < target) begin
        first <= probe + CW'(1);
        count <= count - half - CW'(1);
      end else begin
        count <= half;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      target <= $signed(data_value);
    end
    if (cmd.fin_a) begin
      single <= at_front || past_end;
    end
    if (cmd.fin_b) begin
      lo <= rdata;
    end
    if (cmd.pick) begin
      res <= (single || (mag_lo < mag_hi)) ? lo : rdata;
    end
  end

  // 33-bit distances, cannot overflow
  assign d_lo   = {lo[DW-1], lo} - {target[DW-1], target};
  assign d_hi   = {rdata[DW-1], rdata} - {target[DW-1], target};
  assign mag_lo = d_lo[DW] ? -d_lo : d_lo;
  assign mag_hi = d_hi[DW] ? -d_hi : d_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_tdata <= res;
    end
  end

  assign st.count_zero = (count == '0);
  assign st.out_free   = !m_tvalid || m_tready;

  assign span = {1'b0, first} + {1'b0, count};

  `SCVS_ASSERT_NOW(a_range_in_table, clk, rst,
    1'b1, span <= {1'b0, n_q},
    "search range runs past the entries in use")

  `SCVS_ASSERT_NOW(a_no_overwrite, clk, rst,
    cmd.load, !m_tvalid || m_tready,
    "result loaded over one still waiting")

endmodule

`default_nettype wire

// File: src/sorted_closest_value_search.sv
// Sorted closest value search: holds a table of signed 32-bit values, kept in
// ascending order by the user, and answers queries with the entry nearest a
// target (ties go to the larger). Write items (tuser 0) store one entry and
// give no result. A query (tuser 1) runs a lower-bound binary search with one
// RAM probe per SEARCH and CMP state pair, then reads the two neighbours and
// compares 33-bit distances. The table RAM has a single, registered read port.
// A stalled result holds the block; a new item is taken once the result sits
// in the output register. num_elements is clamped to 1..TABLE_DEPTH and must
// only change while no query is in flight.
// Depends on scvs_pkg, scvs_ctrl, scvs_dp and scvs_ram.
`timescale 1ns / 1ps
`default_nettype none

module sorted_closest_value_search #(
  parameter int TABLE_DEPTH = scvs_pkg::DEF_TABLE_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [scvs_pkg::NUM_W-1:0]       cfg_wdata,  // num_elements
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // [9:0] entry_index, [41:10] data_value, [47:42] zero
  input  wire logic [scvs_pkg::S_TDATA_W-1:0]   s_tdata,
  input  wire logic [0:0]                       s_tuser,    // [0] req_type
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic      [scvs_pkg::DATA_W-1:0]      m_tdata     // [31:0] closest_value
);

  scvs_pkg::cmd_t  cmd;
  scvs_pkg::stat_t st;

  scvs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .is_query (s_tuser[0]),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  scvs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .is_query    (s_tuser[0]),
    .entry_index (s_tdata[scvs_pkg::IDX_W-1:0]),
    .data_value  (s_tdata[scvs_pkg::IDX_W +: scvs_pkg::DATA_W]),
    .cmd         (cmd),
    .st          (st),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

`default_nettype wire
